// ===== rtl/pfcr_pkg.sv =====
package pfcr_pkg;

    // Field widths of the streams and the register
    localparam int ROOT_W        = 32;
    localparam int COEFF_W       = 64;
    localparam int IDX_W         = 5;
    localparam int TOL_W         = 32;
    localparam int MAX_ROOTS_DEF = 16;

    localparam logic [TOL_W-1:0]   TOL_RESET = 32'd4096;
    localparam logic [COEFF_W-1:0] ONE_Q32   = 64'h0000_0001_0000_0000;

    // One complex Q32.32 coefficient as kept in the coefficient memory
    typedef struct packed {
        logic [COEFF_W-1:0] re;
        logic [COEFF_W-1:0] im;
    } t_cplx;

    // Step control from the sequencer into the multiply-subtract pipe
    typedef struct packed {
        logic valid;
        logic top;     // step works on the implicit leading one
        logic bottom;  // step has no lower coefficient
        logic last;    // final step of the pass
    } t_mac_ctl;

    // Write-back status from the pipe
    typedef struct packed {
        logic we;
        logic last;
        logic ovf;
    } t_wb;

endpackage

// ===== rtl/pfcr_if.sv =====
interface pfcr_root_if import pfcr_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic signed [ROOT_W-1:0] root_real;
    logic signed [ROOT_W-1:0] root_imag;
    logic                     has_root;
    logic                     last_root;

    modport source (output valid, root_real, root_imag, has_root, last_root, input ready);
    modport sink   (input valid, root_real, root_imag, has_root, last_root, output ready);
endinterface

interface pfcr_coeff_if import pfcr_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COEFF_W-1:0] coeff_value;
    logic [IDX_W-1:0]          coeff_index;
    logic                      not_conjugate;
    logic                      overflowed;
    logic                      too_many_roots;
    logic                      last_coeff;

    modport source (output valid, coeff_value, coeff_index, not_conjugate, overflowed,
                    too_many_roots, last_coeff, input ready);
    modport sink   (input valid, coeff_value, coeff_index, not_conjugate, overflowed,
                    too_many_roots, last_coeff, output ready);
endinterface

interface pfcr_cfg_if import pfcr_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [TOL_W-1:0] imag_tolerance;

    modport source (output valid, imag_tolerance, input ready);
    modport sink   (input valid, imag_tolerance, output ready);
endinterface

// ===== rtl/poly_from_complex_roots_top.sv =====
// Root beat: one coefficient step per cycle through the memory read port and the complex
// multiply-subtract pipe (partial products, join, floor, subtract and saturate).
// A beat without a root starts no pass. A last_root beat then streams one coefficient beat
// per root held plus the leading one, one per cycle while the sink is ready.
// Reset clears root count and sticky flags and sets imag_tolerance to 4096; the memory
// needs no clearing pass, entries at or above the root count are never used.
module poly_from_complex_roots_top import pfcr_pkg::*; #(
    parameter int MAX_ROOTS = MAX_ROOTS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    pfcr_root_if.sink          i_root,
    pfcr_coeff_if.source       o_coeff,
    pfcr_cfg_if.sink           i_cfg
);

    localparam int AW = (MAX_ROOTS > 1) ? $clog2(MAX_ROOTS) : 1;
    localparam int CW = $clog2(MAX_ROOTS + 1);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_ISSUE = 4'b0010,
        ST_DRAIN = 4'b0100,
        ST_EMIT  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [CW-1:0] r_count, n_count;
    logic [CW-1:0] r_j, n_j;
    logic [CW-1:0] r_k, n_k;
    logic          r_last, n_last;
    logic          r_ovf, n_ovf;
    logic          r_exc, n_exc;
    logic [TOL_W-1:0] r_tol;
    logic signed [ROOT_W-1:0] r_root_re, r_root_im;

    t_mac_ctl      r_ctl;
    logic [AW-1:0] r_idx;
    t_wb           wb;
    logic [AW-1:0] waddr;
    t_cplx         wdata;
    t_cplx         ram_q;

    logic          in_acc;
    logic          take_root;
    logic          rd_en;
    logic [CW-1:0] rd_sel;
    logic          load_out;
    logic          out_free;

    logic          at_top;
    logic [COEFF_W-1:0] emit_re, emit_im, im_mag;
    logic          not_conj;
    logic [CW+IDX_W-1:0] k_ext;

    logic                      r_out_valid;
    logic signed [COEFF_W-1:0] r_out_value;
    logic [IDX_W-1:0]          r_out_index;
    logic                      r_out_nconj, r_out_ovf, r_out_exc, r_out_last;

    assign in_acc       = i_root.valid & i_root.ready;
    assign i_root.ready = (r_state == ST_IDLE);
    assign i_cfg.ready  = 1'b1;
    assign out_free     = ~r_out_valid | o_coeff.ready;

    // Sequence root passes and the coefficient readout
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_j       = r_j;
        n_k       = r_k;
        n_last    = r_last;
        n_ovf     = r_ovf;
        n_exc     = r_exc;
        take_root = 1'b0;
        rd_en     = 1'b0;
        rd_sel    = r_k;
        load_out  = 1'b0;
        if (wb.we && wb.ovf) begin
            n_ovf = 1'b1;
        end
        unique case (r_state)
            ST_IDLE: begin
                if (in_acc) begin
                    if (i_root.has_root && (r_count < CW'(MAX_ROOTS))) begin
                        take_root = 1'b1;
                        n_j       = r_count;
                        n_last    = i_root.last_root;
                        n_state   = ST_ISSUE;
                    end else begin
                        if (i_root.has_root) begin
                            n_exc = 1'b1;
                        end
                        if (i_root.last_root) begin
                            n_state = ST_EMIT;
                            n_k     = '0;
                            rd_en   = 1'b1;
                            rd_sel  = '0;
                        end
                    end
                end
            end
            ST_ISSUE: begin
                rd_en  = (r_j != '0);
                rd_sel = r_j - CW'(1);
                if (r_j == '0) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_j = r_j - CW'(1);
                end
            end
            ST_DRAIN: begin
                if (wb.we && wb.last) begin
                    n_count = r_count + CW'(1);
                    if (r_last) begin
                        n_state = ST_EMIT;
                        n_k     = '0;
                        rd_en   = 1'b1;
                        rd_sel  = '0;
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    load_out = 1'b1;
                    if (r_k == r_count) begin
                        n_state = ST_IDLE;
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_exc   = 1'b0;
                    end else begin
                        n_k    = r_k + CW'(1);
                        rd_en  = 1'b1;
                        rd_sel = r_k + CW'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Hold control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_count   <= '0;
            r_j       <= '0;
            r_k       <= '0;
            r_last    <= 1'b0;
            r_ovf     <= 1'b0;
            r_exc     <= 1'b0;
            r_ctl     <= '0;
            r_tol     <= TOL_RESET;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_j       <= n_j;
            r_k       <= n_k;
            r_last    <= n_last;
            r_ovf     <= n_ovf;
            r_exc     <= n_exc;
            r_ctl.valid  <= (r_state == ST_ISSUE);
            r_ctl.top    <= (r_j == r_count);
            r_ctl.bottom <= (r_j == '0);
            r_ctl.last   <= (r_j == '0);
            if (i_cfg.valid) begin
                r_tol <= i_cfg.imag_tolerance;
            end
        end
    end

    // Latch the root and the step index
    always_ff @(posedge i_clk) begin
        if (take_root) begin
            r_root_re <= i_root.root_real;
            r_root_im <= i_root.root_imag;
        end
        r_idx <= r_j[AW-1:0];
    end

    pfcr_ram #(
        .WIDTH ($bits(t_cplx)),
        .DEPTH (MAX_ROOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (wb.we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_re    (rd_en),
        .i_raddr (rd_sel[AW-1:0]),
        .o_rdata (ram_q)
    );

    pfcr_mac #(
        .MAX_ROOTS (MAX_ROOTS)
    ) u_mac (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (r_ctl),
        .i_idx     (r_idx),
        .i_lower   (ram_q),
        .i_root_re (r_root_re),
        .i_root_im (r_root_im),
        .o_wb      (wb),
        .o_waddr   (waddr),
        .o_wdata   (wdata)
    );

    // Leading coefficient is the implicit one; flag large imaginary parts
    always_comb begin
        at_top   = (r_k == r_count);
        emit_re  = at_top ? ONE_Q32 : ram_q.re;
        emit_im  = at_top ? '0 : ram_q.im;
        im_mag   = emit_im[COEFF_W-1] ? (COEFF_W'(0) - emit_im) : emit_im;
        not_conj = im_mag > {{(COEFF_W-TOL_W){1'b0}}, r_tol};
        k_ext    = {{IDX_W{1'b0}}, r_k};
    end

    // Hold the output beat until the sink takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load_out) begin
            r_out_valid <= 1'b1;
        end else if (o_coeff.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_out_value <= emit_re;
            r_out_index <= k_ext[IDX_W-1:0];
            r_out_nconj <= not_conj;
            r_out_ovf   <= r_ovf;
            r_out_exc   <= r_exc;
            r_out_last  <= at_top;
        end
    end

    assign o_coeff.valid          = r_out_valid;
    assign o_coeff.coeff_value    = r_out_value;
    assign o_coeff.coeff_index    = r_out_index;
    assign o_coeff.not_conjugate  = r_out_nconj;
    assign o_coeff.overflowed     = r_out_ovf;
    assign o_coeff.too_many_roots = r_out_exc;
    assign o_coeff.last_coeff     = r_out_last;

endmodule

// ===== rtl/pfcr_ram.sv =====
module pfcr_ram #(
    parameter int  WIDTH = 128,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write one entry, read one entry with registered data;
    // a read of the entry being written returns the new data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            if (i_we && (i_waddr == i_raddr)) begin
                r_rdata <= i_wdata;
            end else begin
                r_rdata <= r_mem[i_raddr];
            end
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/pfcr_mac.sv =====
module pfcr_mac import pfcr_pkg::*; #(
    parameter int  MAX_ROOTS = MAX_ROOTS_DEF,
    localparam int AW        = (MAX_ROOTS > 1) ? $clog2(MAX_ROOTS) : 1
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_mac_ctl                 i_ctl,
    input  logic [AW-1:0]            i_idx,
    input  t_cplx                    i_lower,
    input  logic signed [ROOT_W-1:0] i_root_re,
    input  logic signed [ROOT_W-1:0] i_root_im,
    output t_wb                      o_wb,
    output logic [AW-1:0]            o_waddr,
    output t_cplx                    o_wdata
);

    // Form a 96-bit product from its upper and lower partial products
    function automatic logic [95:0] join_pp(input logic [63:0] h, input logic [64:0] l);
        return {h, 32'h0} + {{31{l[64]}}, l};
    endfunction

    // Saturate an 82-bit difference to 64 bits; top bit flags saturation
    function automatic logic [64:0] sat_q(input logic [81:0] d);
        logic fits;
        fits = (&d[81:63]) | ~(|d[81:63]);
        if (fits) begin
            return {1'b0, d[63:0]};
        end
        return {1'b1, d[81] ? 64'h8000_0000_0000_0000 : 64'h7FFF_FFFF_FFFF_FFFF};
    endfunction

    t_cplx cur;
    t_cplx low;
    t_cplx r_prev;

    logic          r_b_valid, r_c_valid, r_d_valid;
    logic          r_b_last, r_c_last, r_d_last;
    logic [AW-1:0] r_b_idx, r_c_idx, r_d_idx;
    t_cplx         r_b_low, r_c_low, r_d_low;

    logic [63:0] r_b_rr_h, r_b_ii_h, r_b_ri_h, r_b_ir_h;
    logic [64:0] r_b_rr_l, r_b_ii_l, r_b_ri_l, r_b_ir_l;
    logic [95:0] r_c_rr, r_c_ii, r_c_ri, r_c_ir;
    logic [96:0] pre_re, pre_im;
    logic [80:0] r_d_re, r_d_im;
    logic [81:0] dif_re, dif_im;
    logic [64:0] sat_re, sat_im;

    // Pick the current coefficient and the one below it
    always_comb begin
        cur = i_ctl.top ? t_cplx'{re: ONE_Q32, im: '0} : r_prev;
        low = i_ctl.bottom ? t_cplx'('0) : i_lower;
    end

    // Advance stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_c_valid <= 1'b0;
            r_d_valid <= 1'b0;
        end else begin
            r_b_valid <= i_ctl.valid;
            r_c_valid <= r_b_valid;
            r_d_valid <= r_c_valid;
        end
    end

    // Partial products: each 64-bit part split into signed upper and unsigned lower half
    always_ff @(posedge i_clk) begin
        if (i_ctl.valid) begin
            r_prev   <= low;
            r_b_low  <= low;
            r_b_idx  <= i_idx;
            r_b_last <= i_ctl.last;
            r_b_rr_h <= $signed(cur.re[63:32]) * i_root_re;
            r_b_rr_l <= $signed({1'b0, cur.re[31:0]}) * i_root_re;
            r_b_ii_h <= $signed(cur.im[63:32]) * i_root_im;
            r_b_ii_l <= $signed({1'b0, cur.im[31:0]}) * i_root_im;
            r_b_ri_h <= $signed(cur.re[63:32]) * i_root_im;
            r_b_ri_l <= $signed({1'b0, cur.re[31:0]}) * i_root_im;
            r_b_ir_h <= $signed(cur.im[63:32]) * i_root_re;
            r_b_ir_l <= $signed({1'b0, cur.im[31:0]}) * i_root_re;
        end
    end

    // Join partial products
    always_ff @(posedge i_clk) begin
        if (r_b_valid) begin
            r_c_low  <= r_b_low;
            r_c_idx  <= r_b_idx;
            r_c_last <= r_b_last;
            r_c_rr   <= join_pp(r_b_rr_h, r_b_rr_l);
            r_c_ii   <= join_pp(r_b_ii_h, r_b_ii_l);
            r_c_ri   <= join_pp(r_b_ri_h, r_b_ri_l);
            r_c_ir   <= join_pp(r_b_ir_h, r_b_ir_l);
        end
    end

    // Complex product, then floor to Q32.32
    assign pre_re = {r_c_rr[95], r_c_rr} - {r_c_ii[95], r_c_ii};
    assign pre_im = {r_c_ri[95], r_c_ri} + {r_c_ir[95], r_c_ir};

    always_ff @(posedge i_clk) begin
        if (r_c_valid) begin
            r_d_low  <= r_c_low;
            r_d_idx  <= r_c_idx;
            r_d_last <= r_c_last;
            r_d_re   <= pre_re[96:16];
            r_d_im   <= pre_im[96:16];
        end
    end

    // Subtract from the lower coefficient and saturate
    assign dif_re = {{18{r_d_low.re[63]}}, r_d_low.re} - {r_d_re[80], r_d_re};
    assign dif_im = {{18{r_d_low.im[63]}}, r_d_low.im} - {r_d_im[80], r_d_im};
    assign sat_re = sat_q(dif_re);
    assign sat_im = sat_q(dif_im);

    assign o_wb.we    = r_d_valid;
    assign o_wb.last  = r_d_last;
    assign o_wb.ovf   = sat_re[64] | sat_im[64];
    assign o_waddr    = r_d_idx;
    assign o_wdata.re = sat_re[63:0];
    assign o_wdata.im = sat_im[63:0];

endmodule
